### design/life_like_automaton_torus_assert.svh
// ----------------------------------------------------------------------------
// Life-like automaton: assertion macros
// Implication checks clocked on aclk and switched off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef LIFE_LIKE_AUTOMATON_TORUS_ASSERT_SVH
`define LIFE_LIKE_AUTOMATON_TORUS_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LLA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lla_pkg.sv
// ----------------------------------------------------------------------------
// lla_pkg
// Shared constants and types of the life-like automaton on a torus.
// ----------------------------------------------------------------------------
`default_nettype none

package lla_pkg;

    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 64;

    // item modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_STEP  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_BIRTH   = 2'd0;
    localparam logic [1:0] REG_SURVIVE = 2'd1;
    localparam logic [1:0] REG_WIDTH   = 2'd2;
    localparam logic [1:0] REG_HEIGHT  = 2'd3;

    // register reset values (B3/S23 on 100 x 50)
    localparam logic [8:0] BIRTH_RST   = 9'd8;
    localparam logic [8:0] SURVIVE_RST = 9'd12;
    localparam logic [7:0] WIDTH_RST   = 8'd100;
    localparam logic [6:0] HEIGHT_RST  = 7'd50;

    // generation engine status
    typedef struct packed {
        logic busy;
        logic done;
    } lla_stat_t;

endpackage

`default_nettype wire

### design/lla_ram.sv
// ----------------------------------------------------------------------------
// lla_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lla_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 8192,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/lla_gen_engine.sv
// ----------------------------------------------------------------------------
// lla_gen_engine
// Sweeps the cell memories: clearing pass after reset, bank copy and the
// generation update with a 3 x 3 sliding window (three reads per column).
// ----------------------------------------------------------------------------
`default_nettype none

`include "life_like_automaton_torus_assert.svh"

module lla_gen_engine #(
    parameter int MAX_COLS = lla_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lla_pkg::MAX_ROWS_DEF,
    localparam int CW = $clog2(MAX_COLS),
    localparam int RW = $clog2(MAX_ROWS),
    localparam int AW = CW + RW,
    localparam int DEPTH = MAX_ROWS * (1 << CW)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          go,
    input  wire logic [8:0]    birth_mask,
    input  wire logic [8:0]    survive_mask,
    input  wire logic [CW:0]   eff_w,
    input  wire logic [RW:0]   eff_h,
    input  wire logic          rd_data,
    output logic      [AW-1:0] rd_addr,
    output logic               wr_en,
    output logic               wr_both,
    output logic      [AW-1:0] wr_addr,
    output logic               wr_data,
    output lla_pkg::lla_stat_t stat
);

    typedef enum logic [2:0] {E_IDLE, E_CLEAR, E_COPY, E_GEN, E_DRAIN} eng_state_t;

    // position of a read within the three-row window
    localparam logic [1:0] WIN_ABOVE = 2'd0;
    localparam logic [1:0] WIN_MID   = 2'd1;
    localparam logic [1:0] WIN_BELOW = 2'd2;

    eng_state_t      state_reg;
    logic [AW-1:0]   ca_reg;
    logic [RW-1:0]   row_reg;
    logic [CW-1:0]   colk_reg;
    logic [CW-1:0]   wcol_reg;
    logic [CW+1:0]   kcnt_reg;
    logic [1:0]      j_reg;
    logic            done_reg;

    // read in flight
    logic            tag_v_reg;
    logic            tag_copy_reg;
    logic [AW-1:0]   tag_addr_reg;
    logic [1:0]      tag_j_reg;
    logic            tag_emit_reg;
    logic [RW-1:0]   tag_row_reg;

    // window columns: bit 0 above, bit 1 centre row, bit 2 below
    logic            c0_reg;
    logic            c1_reg;
    logic [2:0]      lcol_reg;
    logic [2:0]      ccol_reg;

    logic [RW:0]     h_last_full;
    logic [CW:0]     w_last_full;
    logic [RW-1:0]   h_last;
    logic [CW-1:0]   w_last;
    logic [RW-1:0]   row_up;
    logic [RW-1:0]   row_dn;
    logic [RW-1:0]   row_sel;
    logic [CW-1:0]   col_nx;
    logic [CW-1:0]   wcol_nx;
    logic [CW+1:0]   kcnt_end;
    logic [CW:0]     wcol_ext;
    logic [2:0]      newcol;
    logic [3:0]      nbr_cnt;
    logic            rule_bit;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] s;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + {3'b000, v[i]};
        end
        return s;
    endfunction

    assign h_last_full = eff_h - (RW+1)'(1);
    assign w_last_full = eff_w - (CW+1)'(1);
    assign h_last      = h_last_full[RW-1:0];
    assign w_last      = w_last_full[CW-1:0];
    assign row_up      = (row_reg == '0) ? h_last : row_reg - 1'b1;
    assign row_dn      = (row_reg == h_last) ? '0 : row_reg + 1'b1;
    assign col_nx      = (colk_reg == w_last) ? '0 : colk_reg + 1'b1;
    assign wcol_nx     = (wcol_reg == w_last) ? '0 : wcol_reg + 1'b1;
    assign kcnt_end    = (CW+2)'(eff_w) + (CW+2)'(1);
    assign wcol_ext    = {1'b0, wcol_reg};

    always_comb begin
        case (j_reg)
            WIN_ABOVE: row_sel = row_up;
            WIN_MID:   row_sel = row_reg;
            default:   row_sel = row_dn;
        endcase
    end

    assign newcol   = {rd_data, c1_reg, c0_reg};
    assign nbr_cnt  = popcount8({lcol_reg, ccol_reg[2], ccol_reg[0], newcol});
    assign rule_bit = ccol_reg[1] ? survive_mask[nbr_cnt] : birth_mask[nbr_cnt];

    assign rd_addr = (state_reg == E_GEN) ? {row_sel, colk_reg} : ca_reg;

    always_comb begin
        wr_en   = 1'b0;
        wr_both = 1'b0;
        wr_addr = ca_reg;
        wr_data = 1'b0;
        if (state_reg == E_CLEAR) begin
            wr_en   = 1'b1;
            wr_both = 1'b1;
        end else if (tag_v_reg && tag_copy_reg) begin
            wr_en   = 1'b1;
            wr_addr = tag_addr_reg;
            wr_data = rd_data;
        end else if (tag_v_reg && (tag_j_reg == WIN_BELOW) && tag_emit_reg) begin
            wr_en   = 1'b1;
            wr_addr = {tag_row_reg, wcol_reg};
            wr_data = rule_bit;
        end
    end

    assign stat.busy = (state_reg != E_IDLE);
    assign stat.done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_CLEAR;
            ca_reg    <= '0;
            tag_v_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            done_reg     <= (state_reg == E_DRAIN);
            tag_v_reg    <= (state_reg == E_COPY) || (state_reg == E_GEN);
            tag_copy_reg <= (state_reg == E_COPY);
            tag_addr_reg <= ca_reg;
            tag_j_reg    <= j_reg;
            tag_emit_reg <= (kcnt_reg >= (CW+2)'(2));
            tag_row_reg  <= row_reg;

            case (state_reg)
                E_IDLE: begin
                    if (go) begin
                        state_reg <= E_COPY;
                        ca_reg    <= '0;
                    end
                end
                E_CLEAR: begin
                    ca_reg <= ca_reg + 1'b1;
                    if (ca_reg == AW'(DEPTH - 1)) begin
                        state_reg <= E_IDLE;
                    end
                end
                E_COPY: begin
                    ca_reg <= ca_reg + 1'b1;
                    if (ca_reg == AW'(DEPTH - 1)) begin
                        state_reg <= E_GEN;
                        row_reg   <= '0;
                        colk_reg  <= w_last;
                        kcnt_reg  <= '0;
                        j_reg     <= WIN_ABOVE;
                        wcol_reg  <= '0;
                    end
                end
                E_GEN: begin
                    if (j_reg == WIN_BELOW) begin
                        j_reg <= WIN_ABOVE;
                        // column sequence per row: w-1, 0, 1 .. w-1, 0
                        if (kcnt_reg == kcnt_end) begin
                            if (row_reg == h_last) begin
                                state_reg <= E_DRAIN;
                            end else begin
                                row_reg  <= row_reg + 1'b1;
                                colk_reg <= w_last;
                                kcnt_reg <= '0;
                            end
                        end else begin
                            colk_reg <= col_nx;
                            kcnt_reg <= kcnt_reg + 1'b1;
                        end
                    end else begin
                        j_reg <= j_reg + 2'd1;
                    end
                end
                E_DRAIN: begin
                    state_reg <= E_IDLE;
                end
                default: begin
                    state_reg <= E_IDLE;
                end
            endcase

            if (tag_v_reg && !tag_copy_reg) begin
                case (tag_j_reg)
                    WIN_ABOVE: c0_reg <= rd_data;
                    WIN_MID:   c1_reg <= rd_data;
                    WIN_BELOW: begin
                        lcol_reg <= ccol_reg;
                        ccol_reg <= newcol;
                        if (tag_emit_reg) begin
                            wcol_reg <= wcol_nx;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    `LLA_ASSERT_NOW(a_idle_no_write, !stat.busy, !wr_en, "memory written while engine idle")
    `LLA_ASSERT_NOW(a_col_count_bound, state_reg == E_GEN, kcnt_reg <= kcnt_end,
        "column count ran past the row")
    `LLA_ASSERT_NOW(a_wcol_in_grid, tag_v_reg && !tag_copy_reg, wcol_ext < eff_w,
        "write column outside active width")

endmodule

`default_nettype wire

### design/life_like_automaton_torus.sv
// ----------------------------------------------------------------------------
// life_like_automaton_torus
// Cell write: accepted in T_IDLE, result from T_RESULT; a cell read also passes
// T_READ to capture the registered bank read. Generation: a bank copy over all
// MAX_ROWS*2^clog2(MAX_COLS) addresses, then 3*(w+2)*h window reads through
// one memory read port. One word in flight: a new word is taken only in T_IDLE;
// the next word is taken while a result waits in m_tdata.
// Reset: registers to B3/S23 100 x 50; a clearing pass over every address zeroes banks.
// ----------------------------------------------------------------------------
`default_nettype none

`include "life_like_automaton_torus_assert.svh"

module life_like_automaton_torus #(
    parameter int MAX_COLS = lla_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lla_pkg::MAX_ROWS_DEF,
    localparam int CW = $clog2(MAX_COLS),
    localparam int RW = $clog2(MAX_ROWS),
    localparam int AW = CW + RW,
    localparam int DEPTH = MAX_ROWS * (1 << CW)
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,    // mode[1:0], row[7:2], col[14:8], cell_in[15]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,    // cell_out[0], zero fill above
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_wdata
);

    typedef enum logic [1:0] {T_IDLE, T_READ, T_GEN, T_RESULT} top_state_t;

    top_state_t         state_reg;
    logic [8:0]         birth_reg;
    logic [8:0]         survive_reg;
    logic [7:0]         width_reg;
    logic [6:0]         height_reg;
    logic               cur_bank_reg;
    logic               rd_ok_reg;
    logic               res_reg;
    logic               m_tvalid_reg;
    logic               m_cell_reg;

    logic [1:0]         in_mode;
    logic [5:0]         in_row;
    logic [6:0]         in_col;
    logic               in_cell;
    logic [CW:0]        eff_w;
    logic [RW:0]        eff_h;
    logic               in_grid;
    logic [AW-1:0]      item_addr;
    logic               accept;
    logic               item_we;
    logic               go;

    lla_pkg::lla_stat_t eng_stat;
    logic [AW-1:0]      eng_rd_addr;
    logic               eng_we;
    logic               eng_both;
    logic [AW-1:0]      eng_wr_addr;
    logic               eng_wr_data;

    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_data;
    logic               we_a;
    logic               we_b;
    logic               rd_a;
    logic               rd_b;
    logic               rd_cur;

    assign in_mode = s_tdata[1:0];
    assign in_row  = s_tdata[7:2];
    assign in_col  = s_tdata[14:8];
    assign in_cell = s_tdata[15];

    // zero treated as one, large values saturate to the storage size
    always_comb begin
        if (width_reg == '0) begin
            eff_w = (CW+1)'(1);
        end else if (32'(width_reg) > 32'(MAX_COLS)) begin
            eff_w = (CW+1)'(MAX_COLS);
        end else begin
            eff_w = (CW+1)'(width_reg);
        end
        if (height_reg == '0) begin
            eff_h = (RW+1)'(1);
        end else if (32'(height_reg) > 32'(MAX_ROWS)) begin
            eff_h = (RW+1)'(MAX_ROWS);
        end else begin
            eff_h = (RW+1)'(height_reg);
        end
    end

    assign in_grid   = (32'(in_row) < 32'(eff_h)) && (32'(in_col) < 32'(eff_w));
    assign item_addr = {RW'(in_row), CW'(in_col)};

    assign s_tready = (state_reg == T_IDLE) && !eng_stat.busy;
    assign accept   = s_tvalid && s_tready;
    assign item_we  = accept && (in_mode == lla_pkg::MODE_WRITE) && in_grid;
    assign go       = accept && (in_mode == lla_pkg::MODE_STEP);

    // engine owns both banks while busy: reads current, writes the other (both while clearing)
    assign rd_addr = eng_stat.busy ? eng_rd_addr : item_addr;
    assign wr_addr = eng_stat.busy ? eng_wr_addr : item_addr;
    assign wr_data = eng_stat.busy ? eng_wr_data : in_cell;
    assign we_a    = eng_stat.busy ? (eng_we && (eng_both || cur_bank_reg))
                                   : (item_we && !cur_bank_reg);
    assign we_b    = eng_stat.busy ? (eng_we && (eng_both || !cur_bank_reg))
                                   : (item_we && cur_bank_reg);
    assign rd_cur  = cur_bank_reg ? rd_b : rd_a;

    lla_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_bank_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_a)
    );

    lla_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_bank_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_b)
    );

    lla_gen_engine #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .go           (go),
        .birth_mask   (birth_reg),
        .survive_mask (survive_reg),
        .eff_w        (eff_w),
        .eff_h        (eff_h),
        .rd_data      (rd_cur),
        .rd_addr      (eng_rd_addr),
        .wr_en        (eng_we),
        .wr_both      (eng_both),
        .wr_addr      (eng_wr_addr),
        .wr_data      (eng_wr_data),
        .stat         (eng_stat)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0000000, m_cell_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IDLE;
            birth_reg    <= lla_pkg::BIRTH_RST;
            survive_reg  <= lla_pkg::SURVIVE_RST;
            width_reg    <= lla_pkg::WIDTH_RST;
            height_reg   <= lla_pkg::HEIGHT_RST;
            cur_bank_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    lla_pkg::REG_BIRTH:   birth_reg   <= cfg_wdata;
                    lla_pkg::REG_SURVIVE: survive_reg <= cfg_wdata;
                    lla_pkg::REG_WIDTH:   width_reg   <= cfg_wdata[7:0];
                    lla_pkg::REG_HEIGHT:  height_reg  <= cfg_wdata[6:0];
                    default: begin
                    end
                endcase
            end

            // T_RESULT refills the output slot itself
            if (m_tvalid_reg && m_tready && (state_reg != T_RESULT)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                T_IDLE: begin
                    if (accept) begin
                        rd_ok_reg <= in_grid;
                        res_reg   <= 1'b0;
                        case (in_mode)
                            lla_pkg::MODE_READ: state_reg <= T_READ;
                            lla_pkg::MODE_STEP: state_reg <= T_GEN;
                            default:            state_reg <= T_RESULT;
                        endcase
                    end
                end
                T_READ: begin
                    res_reg   <= rd_ok_reg & rd_cur;
                    state_reg <= T_RESULT;
                end
                T_GEN: begin
                    if (eng_stat.done) begin
                        cur_bank_reg <= ~cur_bank_reg;
                        state_reg    <= T_RESULT;
                    end
                end
                T_RESULT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_cell_reg   <= res_reg;
                        state_reg    <= T_IDLE;
                    end
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    `LLA_ASSERT_NOW(a_no_item_write_busy, eng_stat.busy, !item_we,
        "cell write while generation running")
    `LLA_ASSERT_NEXT(a_step_starts_engine, go, eng_stat.busy, "generation did not start")
    `LLA_ASSERT_NOW(a_bank_swap_on_done, cur_bank_reg != $past(cur_bank_reg),
        $past(eng_stat.done), "bank swapped outside generation end")

endmodule

`default_nettype wire
